### design/shfp_pkg.sv
`timescale 1ns / 1ps
// Types and constants shared by the slice header field parser.
// No dependencies; imported by the controller, the datapath and the top level.
package shfp_pkg;

  // Result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_ERROR = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_SEP_PLANES   = 3'd0;
  localparam logic [2:0] CFG_FRAME_NUM_WM4 = 3'd1;
  localparam logic [2:0] CFG_FRAMES_ONLY  = 3'd2;
  localparam logic [2:0] CFG_POC_MODE     = 3'd3;
  localparam logic [2:0] CFG_POC_LSB_WM4  = 3'd4;

  // Header field sequence
  localparam logic [3:0] STEP_FIRST_MB = 4'd0;
  localparam logic [3:0] STEP_SLICE    = 4'd1;
  localparam logic [3:0] STEP_PPS      = 4'd2;
  localparam logic [3:0] STEP_PLANE    = 4'd3;
  localparam logic [3:0] STEP_FRAME    = 4'd4;
  localparam logic [3:0] STEP_FIELD    = 4'd5;
  localparam logic [3:0] STEP_BOTTOM   = 4'd6;
  localparam logic [3:0] STEP_IDR      = 4'd7;
  localparam logic [3:0] STEP_POC      = 4'd8;
  localparam logic [3:0] STEP_DONE     = 4'd9;

  localparam logic [4:0] IDR_NAL_TYPE     = 5'd5;
  localparam logic [3:0] MAX_WIDTH_MINUS4 = 4'd12;
  localparam logic [4:0] WIDTH_OFFSET     = 5'd4;
  localparam logic [4:0] PLANE_BITS       = 5'd2;
  localparam logic [5:0] MAX_ZEROS        = 6'd31;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_byte;
    logic [4:0] nal_type;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] first_mb;
    logic [31:0] slice_kind;
    logic [31:0] pps_index;
    logic [1:0]  plane_id;
    logic [15:0] frame_number;
    logic        field_pic;
    logic        bottom_field;
    logic [31:0] idr_id;
    logic [15:0] poc_lsb;
    logic [2:0]  present_mask;
  } out_beat_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic bit_en;
    logic finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic emit;
    logic hdr_done;
    logic stop_now;
  } status_t;

endpackage

### design/shfp_datapath.sv
`timescale 1ns / 1ps
// Datapath of the slice header field parser: config registers, bit shifter,
// Exp-Golomb and fixed-width field decoder, held fields and result register. Uses shfp_pkg.
module shfp_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_index_i,
  input  logic [3:0]           cfg_wdata_i,
  input  shfp_pkg::in_beat_t   in_data_i,
  input  shfp_pkg::cmd_t       cmd_i,
  output shfp_pkg::status_t    status_o,
  output shfp_pkg::out_beat_t  out_data_o
);
  import shfp_pkg::*;

  // Configuration
  logic       sep_planes_q, frames_only_q;
  logic [3:0] fn_wm4_q, poc_wm4_q;
  logic [1:0] poc_mode_q;

  // Current beat
  logic [7:0] shift_q, shift_d;
  logic       item_valid_q, item_valid_d, item_last_q, item_last_d;

  // Slice state
  logic        in_slice_q, in_slice_d;
  logic [4:0]  nal_q, nal_d;
  logic [3:0]  step_q, step_d;
  logic        phase_q, phase_d;
  logic [5:0]  zcount_q, zcount_d;
  logic [4:0]  brem_q, brem_d;
  logic [31:0] partial_q, partial_d;
  logic [31:0] gol_q [4];
  logic [31:0] gol_d [4];
  logic [1:0]  plane_q, plane_d;
  logic [15:0] frame_q, frame_d;
  logic        field_q, field_d, bottom_q, bottom_d;
  logic [15:0] poc_q, poc_d;
  logic [2:0]  present_q, present_d;
  logic        hdr_done_q, hdr_done_d;
  logic        done_now_q, done_now_d;
  logic        mal_q, mal_d;

  out_beat_t   out_q, out_d;

  logic        bit_in, complete, malformed, field_flag, emit;
  logic [31:0] cval, pnext;
  logic [4:0]  brem_dec;
  logic [3:0]  next_step;
  logic [9:0]  pres;
  logic [4:0]  next_width;
  logic [3:0]  fn_clamp, poc_clamp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_planes_q  <= 1'b0;
      fn_wm4_q      <= 4'd0;
      frames_only_q <= 1'b1;
      poc_mode_q    <= 2'd0;
      poc_wm4_q     <= 4'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SEP_PLANES:    sep_planes_q  <= cfg_wdata_i[0];
        CFG_FRAME_NUM_WM4: fn_wm4_q      <= cfg_wdata_i;
        CFG_FRAMES_ONLY:   frames_only_q <= cfg_wdata_i[0];
        CFG_POC_MODE:      poc_mode_q    <= cfg_wdata_i[1:0];
        CFG_POC_LSB_WM4:   poc_wm4_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign fn_clamp  = (fn_wm4_q > MAX_WIDTH_MINUS4) ? MAX_WIDTH_MINUS4 : fn_wm4_q;
  assign poc_clamp = (poc_wm4_q > MAX_WIDTH_MINUS4) ? MAX_WIDTH_MINUS4 : poc_wm4_q;

  assign bit_in = shift_q[7];
  assign pnext  = {partial_q[30:0], bit_in};
  assign brem_dec = brem_q - 5'd1;

  // Bit decode for the current field
  always_comb begin
    complete  = 1'b0;
    malformed = 1'b0;
    cval      = 32'd0;
    if (!phase_q) begin
      if (!bit_in) begin
        malformed = (zcount_q == MAX_ZEROS);
      end else if (zcount_q == 6'd0) begin
        complete = 1'b1;
      end
    end else if (brem_dec == 5'd0) begin
      complete = 1'b1;
      if (step_q <= STEP_PPS || step_q == STEP_IDR) begin
        cval = pnext - 32'd1;
      end else begin
        cval = pnext;
      end
    end
  end

  // Skip absent fields; the bottom-field flag follows the field flag just read
  assign field_flag = (step_q == STEP_FIELD) ? cval[0] : field_q;

  always_comb begin
    pres = 10'b1_0000_1_0_111;
    pres[STEP_PLANE]  = sep_planes_q;
    pres[STEP_FIELD]  = !frames_only_q;
    pres[STEP_BOTTOM] = field_flag;
    pres[STEP_IDR]    = (nal_q == IDR_NAL_TYPE);
    pres[STEP_POC]    = (poc_mode_q == 2'd0);
    next_step = STEP_DONE;
    for (int i = 9; i >= 1; i--) begin
      if (4'(i) > step_q && pres[i]) begin
        next_step = 4'(i);
      end
    end
  end

  always_comb begin
    case (next_step)
      STEP_PLANE:  next_width = PLANE_BITS;
      STEP_FRAME:  next_width = 5'(fn_clamp) + WIDTH_OFFSET;
      STEP_FIELD,
      STEP_BOTTOM: next_width = 5'd1;
      STEP_POC:    next_width = 5'(poc_clamp) + WIDTH_OFFSET;
      default:     next_width = 5'd0;
    endcase
  end

  assign emit = item_valid_q ? (done_now_q || (item_last_q && !hdr_done_q))
                             : (item_last_q && (!in_slice_q || !hdr_done_q));

  always_comb begin
    shift_d      = shift_q;
    item_valid_d = item_valid_q;
    item_last_d  = item_last_q;
    in_slice_d   = in_slice_q;
    nal_d        = nal_q;
    step_d       = step_q;
    phase_d      = phase_q;
    zcount_d     = zcount_q;
    brem_d       = brem_q;
    partial_d    = partial_q;
    gol_d        = gol_q;
    plane_d      = plane_q;
    frame_d      = frame_q;
    field_d      = field_q;
    bottom_d     = bottom_q;
    poc_d        = poc_q;
    present_d    = present_q;
    hdr_done_d   = hdr_done_q;
    done_now_d   = done_now_q;
    mal_d        = mal_q;
    out_d        = out_q;

    if (cmd_i.accept) begin
      shift_d      = in_data_i.data_byte;
      item_valid_d = in_data_i.byte_valid;
      item_last_d  = in_data_i.last_byte;
      done_now_d   = 1'b0;
      mal_d        = 1'b0;
      if (in_data_i.byte_valid && !in_slice_q) begin
        in_slice_d = 1'b1;
        nal_d      = in_data_i.nal_type;
      end
    end

    if (cmd_i.bit_en) begin
      shift_d = {shift_q[6:0], 1'b0};
      if (!phase_q) begin
        if (!bit_in) begin
          zcount_d = zcount_q + 6'd1;
        end else if (zcount_q != 6'd0) begin
          phase_d   = 1'b1;
          brem_d    = zcount_q[4:0];
          partial_d = 32'd1;
        end
      end else begin
        partial_d = pnext;
        brem_d    = brem_dec;
      end
      if (complete) begin
        case (step_q)
          STEP_FIRST_MB, STEP_SLICE, STEP_PPS: gol_d[step_q[1:0]] = cval;
          STEP_PLANE: begin
            plane_d      = cval[1:0];
            present_d[0] = 1'b1;
          end
          STEP_FRAME:  frame_d  = cval[15:0];
          STEP_FIELD:  field_d  = cval[0];
          STEP_BOTTOM: bottom_d = cval[0];
          STEP_IDR: begin
            gol_d[3]     = cval;
            present_d[1] = 1'b1;
          end
          STEP_POC: begin
            poc_d        = cval[15:0];
            present_d[2] = 1'b1;
          end
          default: ;
        endcase
        step_d    = next_step;
        zcount_d  = 6'd0;
        partial_d = 32'd0;
        brem_d    = next_width;
        phase_d   = !(next_step <= STEP_PPS || next_step == STEP_IDR);
        if (next_step == STEP_DONE) begin
          hdr_done_d = 1'b1;
          done_now_d = 1'b1;
        end
      end
      if (malformed) begin
        hdr_done_d = 1'b1;
        done_now_d = 1'b1;
        mal_d      = 1'b1;
      end
    end

    if (cmd_i.finish) begin
      if (emit) begin
        if (!item_valid_q && !in_slice_q) begin
          out_d.status = STATUS_EMPTY;
        end else if (done_now_q && !mal_q) begin
          out_d.status = STATUS_OK;
        end else begin
          out_d.status = STATUS_ERROR;
        end
        out_d.first_mb     = gol_q[0];
        out_d.slice_kind   = gol_q[1];
        out_d.pps_index    = gol_q[2];
        out_d.plane_id     = plane_q;
        out_d.frame_number = frame_q;
        out_d.field_pic    = field_q;
        out_d.bottom_field = bottom_q;
        out_d.idr_id       = gol_q[3];
        out_d.poc_lsb      = poc_q;
        out_d.present_mask = present_q;
      end
      // End of slice: clear the slice state; the configuration is kept
      if (item_last_q) begin
        in_slice_d = 1'b0;
        nal_d      = 5'd0;
        step_d     = STEP_FIRST_MB;
        phase_d    = 1'b0;
        zcount_d   = 6'd0;
        brem_d     = 5'd0;
        partial_d  = 32'd0;
        for (int i = 0; i < 4; i++) begin
          gol_d[i] = 32'd0;
        end
        plane_d    = 2'd0;
        frame_d    = 16'd0;
        field_d    = 1'b0;
        bottom_d   = 1'b0;
        poc_d      = 16'd0;
        present_d  = 3'd0;
        hdr_done_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      item_last_q  <= 1'b0;
      in_slice_q   <= 1'b0;
      nal_q        <= 5'd0;
      step_q       <= STEP_FIRST_MB;
      phase_q      <= 1'b0;
      zcount_q     <= 6'd0;
      brem_q       <= 5'd0;
      partial_q    <= 32'd0;
      for (int i = 0; i < 4; i++) begin
        gol_q[i] <= 32'd0;
      end
      plane_q      <= 2'd0;
      frame_q      <= 16'd0;
      field_q      <= 1'b0;
      bottom_q     <= 1'b0;
      poc_q        <= 16'd0;
      present_q    <= 3'd0;
      hdr_done_q   <= 1'b0;
      done_now_q   <= 1'b0;
      mal_q        <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
      item_last_q  <= item_last_d;
      in_slice_q   <= in_slice_d;
      nal_q        <= nal_d;
      step_q       <= step_d;
      phase_q      <= phase_d;
      zcount_q     <= zcount_d;
      brem_q       <= brem_d;
      partial_q    <= partial_d;
      gol_q        <= gol_d;
      plane_q      <= plane_d;
      frame_q      <= frame_d;
      field_q      <= field_d;
      bottom_q     <= bottom_d;
      poc_q        <= poc_d;
      present_q    <= present_d;
      hdr_done_q   <= hdr_done_d;
      done_now_q   <= done_now_d;
      mal_q        <= mal_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    out_q   <= out_d;
  end

  assign status_o.emit     = emit;
  assign status_o.hdr_done = hdr_done_q;
  assign status_o.stop_now = malformed || (complete && next_step == STEP_DONE);
  assign out_data_o        = out_q;

`ifndef SYNTHESIS
  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.bit_en && status_o.stop_now |=> hdr_done_q && done_now_q)
    else $error("header completion not recorded");

  a_no_bits_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.bit_en |-> !hdr_done_q && step_q != STEP_DONE)
    else $error("bit consumed after header end");

  a_step_done_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q == STEP_DONE |-> hdr_done_q)
    else $error("field sequence ended without header done");
`endif

endmodule

### design/shfp_ctrl.sv
`timescale 1ns / 1ps
// Controller of the slice header field parser: beat acceptance, per-bit
// sequencing and result register handshake. Uses shfp_pkg.
module shfp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_byte_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  shfp_pkg::status_t   status_i,
  output shfp_pkg::cmd_t      cmd_o
);
  import shfp_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_BITS   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0] state_q, state_d;
  logic [2:0] bit_cnt_q, bit_cnt_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d   = state_q;
    bit_cnt_d = bit_cnt_q;
    cmd_o     = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          bit_cnt_d    = 3'd0;
          state_d      = (in_byte_valid_i && !status_i.hdr_done) ? S_BITS : S_FINISH;
        end
      end
      S_BITS: begin
        cmd_o.bit_en = 1'b1;
        bit_cnt_d    = bit_cnt_q + 3'd1;
        if (status_i.stop_now || bit_cnt_q == 3'd7) begin
          bit_cnt_d = 3'd0;
          state_d   = S_FINISH;
        end
      end
      S_FINISH: begin
        // hold while a previous result still waits and this beat has a result to emit
        if (!(status_i.emit && out_valid_q && out_stall_i)) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = (cmd_o.finish && status_i.emit) ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bit_cnt_q   <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bit_cnt_q   <= bit_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish && status_i.emit |-> !(out_valid_q && out_stall_i))
    else $error("result register overwritten");

  a_bits_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_BITS && bit_cnt_q == 3'd7 |=> state_q == S_FINISH)
    else $error("more than eight bits for one beat");

  a_idle_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> bit_cnt_q == 3'd0)
    else $error("bit counter not cleared");

  a_bits_open_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_BITS |-> !status_i.hdr_done)
    else $error("bit phase with header already done");
`endif

endmodule

### design/slice_header_field_parser.sv
`timescale 1ns / 1ps
// Slice header field parser, top level: joins controller and datapath.
// Depends on shfp_pkg, shfp_ctrl and shfp_datapath.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one RBSP byte
//   per beat, with byte_valid, last_byte and nal_type. A beat with byte_valid
//   low and last_byte low is dropped; last_byte ends the slice.
//   Output channel (out_valid_o / out_stall_i / out_data_o) carries at most
//   one result per slice: when the header completes, on a malformed code, or
//   at the end of a slice whose header did not complete (or was empty).
//   Configuration writes (cfg_we_i, cfg_index_i, cfg_wdata_i) are registered
//   and are meant for idle periods between slices.
// Timing:
//   A byte beat is accepted, shifted bit by bit through the serial Golomb/field
//   decoder (at most eight header bits), then finished. Beats after the header is
//   complete, and empty beats, skip the bit phase.
//   A result appears the cycle after the finishing cycle.
// Reset and stall:
//   Reset clears the slice state and loads the register defaults (frames only).
//   The result register holds its beat under out_stall_i; the next byte is
//   still accepted and decoded, and only a second result waits for it.
module slice_header_field_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  shfp_pkg::in_beat_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output shfp_pkg::out_beat_t  out_data_o,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_index_i,
  input  logic [3:0]           cfg_wdata_i
);
  import shfp_pkg::*;

  cmd_t    cmd;
  status_t status;

  shfp_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_byte_valid_i (in_data_i.byte_valid),
    .in_stall_o      (in_stall_o),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_i        (status),
    .cmd_o           (cmd)
  );

  shfp_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

endmodule
